>>> rtl/gert_pkg.sv
// Package for the grid empty run tracker.
// Holds the item payload structs, control structs, sequencer states and widths.
// No dependencies.
package gert_pkg;

  localparam int RUN_W = 6;
  localparam int CNT_W = 11;
  localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;

  typedef struct packed {
    logic       func;
    logic [4:0] pos_x;
    logic [4:0] pos_y;
    logic [5:0] rect_w;
    logic [5:0] rect_h;
  } gert_in_t;

  typedef struct packed {
    logic [5:0]       bin_length;
    logic [CNT_W-1:0] cell_count;
    logic             last_bin;
  } gert_out_t;

  typedef struct packed {
    logic req;
    logic upd;
  } gert_line_op_t;

  typedef struct packed {
    logic clr;
    logic inc;
    logic rd;
  } gert_hist_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLACE,
    ST_SCAN,
    ST_DRAIN,
    ST_SETTLE,
    ST_READ,
    ST_WAIT
  } gert_state_e;

endpackage

>>> rtl/gert_run_calc.sv
// Empty run length of every cell of one grid line.
// Combinational; depends on gert_pkg for the run width.
module gert_run_calc import gert_pkg::*; #(
  parameter int LEN = 32
) (
  input  logic [LEN-1:0]            occ_i,
  output logic [LEN-1:0][RUN_W-1:0] run_o
);

  logic [RUN_W-1:0] left [LEN];
  logic [RUN_W-1:0] right [LEN];

  always_comb begin
    for (int i = 0; i < LEN; i++) begin
      left[i] = '0;
      for (int j = 0; j <= i; j++) begin
        if (occ_i[j]) begin
          left[i] = RUN_W'(j + 1);
        end
      end
      right[i] = RUN_W'(LEN);
      for (int j = LEN - 1; j >= i; j--) begin
        if (occ_i[j]) begin
          right[i] = RUN_W'(j);
        end
      end
      run_o[i] = occ_i[i] ? '0 : right[i] - left[i];
    end
  end

endmodule

>>> rtl/gert_line_store.sv
// Line store: occupancy and run lengths of every line (row or column) of the grid.
// Registered read, read-modify-write update with run recompute; uses gert_pkg, gert_run_calc.
module gert_line_store import gert_pkg::*; #(
  parameter  int LEN   = 32,
  parameter  int DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gert_line_op_t             op_i,
  input  logic [AW-1:0]             addr_i,
  input  logic [LEN-1:0]            mask_i,
  output logic [LEN-1:0][RUN_W-1:0] run_o
);

  logic [LEN-1:0]            occ_mem [DEPTH];
  logic [LEN-1:0][RUN_W-1:0] run_mem [DEPTH];
  logic [DEPTH-1:0]          vld_q;

  logic [LEN-1:0]            occ_rd_q;
  logic [LEN-1:0][RUN_W-1:0] run_rd_q;
  logic                      rvld_q;
  logic                      pend_q;
  logic [AW-1:0]             pend_addr_q;
  logic [LEN-1:0]            pend_mask_q;

  logic [LEN-1:0]            occ_new;
  logic [LEN-1:0][RUN_W-1:0] run_new;

  assign occ_new = (rvld_q ? occ_rd_q : '0) | pend_mask_q;

  gert_run_calc #(
    .LEN (LEN)
  ) u_run_calc (
    .occ_i (occ_new),
    .run_o (run_new)
  );

  always_ff @(posedge clk_i) begin
    if (op_i.req) begin
      occ_rd_q <= occ_mem[addr_i];
      run_rd_q <= run_mem[addr_i];
    end
    if (pend_q) begin
      occ_mem[pend_addr_q] <= occ_new;
      run_mem[pend_addr_q] <= run_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.req) begin
      pend_addr_q <= addr_i;
      pend_mask_q <= mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= op_i.req & op_i.upd;
      if (op_i.req) begin
        rvld_q <= vld_q[addr_i];
      end
      if (pend_q) begin
        vld_q[pend_addr_q] <= 1'b1;
      end
    end
  end

  // unwritten lines read as fully empty
  always_comb begin
    for (int i = 0; i < LEN; i++) begin
      run_o[i] = rvld_q ? run_rd_q[i] : RUN_W'(LEN);
    end
  end

endmodule

>>> rtl/gert_hist_acc.sv
// Histogram accumulator: saturating bin counters in a registered-read memory.
// Increment with write forwarding, per-bin valid bits for clearing; uses gert_pkg.
module gert_hist_acc import gert_pkg::*; #(
  parameter  int BINS = 33,
  localparam int BW   = (BINS > 1) ? $clog2(BINS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gert_hist_op_t    op_i,
  input  logic [BW-1:0]    inc_bin_i,
  input  logic [BW-1:0]    rd_bin_i,
  output logic [CNT_W-1:0] cnt_o
);

  logic [CNT_W-1:0] hist_mem [BINS];
  logic [BINS-1:0]  bvld_q;

  logic             re;
  logic [BW-1:0]    raddr;
  logic [CNT_W-1:0] rdata_q;
  logic             rvld_q;
  logic             s1_q;
  logic [BW-1:0]    s1_bin_q;
  logic             wr_vld_q;
  logic [BW-1:0]    wr_bin_q;
  logic [CNT_W-1:0] wr_cnt_q;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] sum;

  assign re    = op_i.inc | op_i.rd;
  assign raddr = op_i.inc ? inc_bin_i : rd_bin_i;

  // forward the previous write, which the memory read missed
  assign base  = (wr_vld_q && (wr_bin_q == s1_bin_q)) ? wr_cnt_q :
                 (rvld_q ? rdata_q : '0);
  assign sum   = (base == CNT_MAX) ? base : base + CNT_W'(1);
  assign cnt_o = rvld_q ? rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= hist_mem[raddr];
    end
    if (s1_q) begin
      hist_mem[s1_bin_q] <= sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.inc) begin
      s1_bin_q <= inc_bin_i;
    end
    if (s1_q) begin
      wr_bin_q <= s1_bin_q;
      wr_cnt_q <= sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvld_q   <= '0;
      rvld_q   <= 1'b0;
      s1_q     <= 1'b0;
      wr_vld_q <= 1'b0;
    end else begin
      s1_q     <= op_i.inc;
      wr_vld_q <= s1_q & ~op_i.clr;
      if (re) begin
        rvld_q <= bvld_q[raddr];
      end
      if (op_i.clr) begin
        bvld_q <= '0;
      end else if (s1_q) begin
        bvld_q[s1_bin_q] <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/grid_empty_run_tracker.sv
// Grid empty run tracker top level: sequencer, row and column line stores, histogram.
// Uses gert_pkg, gert_line_store, gert_hist_acc.
//
// Input channel in_valid_i/in_ready_o carries one gert_in_t item. Output channel
// out_valid_o/out_ready_i carries gert_out_t histogram bins.
// A place item (func 0) ORs the clipped rectangle into the grid and rewrites the
// touched rows and columns in parallel, one row and one column per cycle through
// the read-modify-write port of each line store. A rectangle that misses the grid,
// or has zero width or height, leaves the grid unchanged.
// A histogram item (func 1) scans every cell, one cell per cycle, with a bin
// increment in the histogram memory, then emits min(GRID_WIDTH,GRID_HEIGHT)+1
// bins, each through the ST_READ and ST_WAIT states, last_bin on the last.
// A single output register holds a bin while the receiver stalls; the readout
// waits for it. in_ready_o rises again once the last bin is in that register.
// Reset clears the grid to all free with full-length runs at once via per-line
// valid bits; no clearing pass is needed.
module grid_empty_run_tracker import gert_pkg::*; #(
  parameter int GRID_WIDTH  = 32,
  parameter int GRID_HEIGHT = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  gert_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output gert_out_t out_data_o
);

  localparam int MIN_DIM = (GRID_WIDTH < GRID_HEIGHT) ? GRID_WIDTH : GRID_HEIGHT;
  localparam int BINS    = MIN_DIM + 1;
  localparam int BW      = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int XW      = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int YW      = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

  gert_state_e state_q, state_d;

  logic                  in_acc;
  logic                  place_ok;
  logic [6:0]            xe;
  logic [6:0]            ye;
  logic [GRID_WIDTH-1:0] row_mask_d;
  logic [GRID_HEIGHT-1:0] col_mask_d;

  logic [RUN_W-1:0]       row_q, row_end_q, col_q, col_end_q;
  logic [GRID_WIDTH-1:0]  row_mask_q;
  logic [GRID_HEIGHT-1:0] col_mask_q;
  logic                   row_done, col_done;

  logic [XW-1:0] x_q, sx_q;
  logic [YW-1:0] y_q, sy_q;
  logic          x_last, y_last;
  logic          s_vld_q;

  logic [RUN_W-1:0] bin_q;
  logic             bin_last;
  logic             out_load;
  logic             out_valid_q;
  gert_out_t        out_data_q;

  gert_line_op_t row_op, col_op;
  logic [YW-1:0] row_addr;
  logic [XW-1:0] col_addr;
  logic [GRID_WIDTH-1:0][RUN_W-1:0]  row_run;
  logic [GRID_HEIGHT-1:0][RUN_W-1:0] col_run;

  gert_hist_op_t    hist_op;
  logic [RUN_W-1:0] run_h, run_v, run_m;
  logic [BW-1:0]    inc_bin;
  logic [CNT_W-1:0] hist_cnt;

  // clip the rectangle
  always_comb begin
    place_ok = (7'(in_data_i.pos_x) < 7'(GRID_WIDTH)) &&
               (7'(in_data_i.pos_y) < 7'(GRID_HEIGHT)) &&
               (in_data_i.rect_w != '0) && (in_data_i.rect_h != '0);
    xe = 7'(in_data_i.pos_x) + 7'(in_data_i.rect_w);
    if (xe > 7'(GRID_WIDTH)) begin
      xe = 7'(GRID_WIDTH);
    end
    ye = 7'(in_data_i.pos_y) + 7'(in_data_i.rect_h);
    if (ye > 7'(GRID_HEIGHT)) begin
      ye = 7'(GRID_HEIGHT);
    end
    for (int i = 0; i < GRID_WIDTH; i++) begin
      row_mask_d[i] = (7'(i) >= 7'(in_data_i.pos_x)) && (7'(i) < xe);
    end
    for (int j = 0; j < GRID_HEIGHT; j++) begin
      col_mask_d[j] = (7'(j) >= 7'(in_data_i.pos_y)) && (7'(j) < ye);
    end
  end

  assign row_done = (row_q == row_end_q);
  assign col_done = (col_q == col_end_q);
  assign x_last   = (x_q == XW'(GRID_WIDTH - 1));
  assign y_last   = (y_q == YW'(GRID_HEIGHT - 1));
  assign bin_last = (bin_q == RUN_W'(MIN_DIM));
  assign in_acc   = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.func) begin
            state_d = ST_SCAN;
          end else if (place_ok) begin
            state_d = ST_PLACE;
          end
        end
      end
      ST_PLACE: begin
        if (row_done && col_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (x_last && y_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_SETTLE;
      ST_SETTLE: state_d = ST_READ;
      ST_READ:   state_d = ST_WAIT;
      ST_WAIT: begin
        if (out_load) begin
          state_d = bin_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    row_op      = '0;
    col_op      = '0;
    hist_op     = '0;
    out_load    = 1'b0;
    hist_op.inc = s_vld_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        hist_op.clr = in_valid_i & in_data_i.func;
      end
      ST_PLACE: begin
        row_op.req = ~row_done;
        row_op.upd = 1'b1;
        col_op.req = ~col_done;
        col_op.upd = 1'b1;
      end
      ST_SCAN: begin
        row_op.req = 1'b1;
        col_op.req = 1'b1;
      end
      ST_READ: begin
        hist_op.rd = 1'b1;
      end
      ST_WAIT: begin
        out_load = ~out_valid_q | out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign row_addr = (state_q == ST_SCAN) ? y_q : row_q[YW-1:0];
  assign col_addr = (state_q == ST_SCAN) ? x_q : col_q[XW-1:0];

  gert_line_store #(
    .LEN   (GRID_WIDTH),
    .DEPTH (GRID_HEIGHT)
  ) u_row_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (row_op),
    .addr_i (row_addr),
    .mask_i (row_mask_q),
    .run_o  (row_run)
  );

  gert_line_store #(
    .LEN   (GRID_HEIGHT),
    .DEPTH (GRID_WIDTH)
  ) u_col_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (col_op),
    .addr_i (col_addr),
    .mask_i (col_mask_q),
    .run_o  (col_run)
  );

  always_comb begin
    run_h = row_run[sx_q];
    run_v = col_run[sy_q];
    run_m = (run_h < run_v) ? run_h : run_v;
    if (run_m > RUN_W'(MIN_DIM)) begin
      run_m = RUN_W'(MIN_DIM);
    end
    inc_bin = run_m[BW-1:0];
  end

  gert_hist_acc #(
    .BINS (BINS)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (hist_op),
    .inc_bin_i (inc_bin),
    .rd_bin_i  (bin_q[BW-1:0]),
    .cnt_o     (hist_cnt)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      row_mask_q <= row_mask_d;
      col_mask_q <= col_mask_d;
    end
    sx_q <= x_q;
    sy_q <= y_q;
    if (out_load) begin
      out_data_q.bin_length <= bin_q;
      out_data_q.cell_count <= hist_cnt;
      out_data_q.last_bin   <= bin_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      row_end_q   <= '0;
      col_q       <= '0;
      col_end_q   <= '0;
      x_q         <= '0;
      y_q         <= '0;
      s_vld_q     <= 1'b0;
      bin_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      s_vld_q <= (state_q == ST_SCAN);
      if (in_acc) begin
        row_q     <= RUN_W'(in_data_i.pos_y);
        row_end_q <= ye[RUN_W-1:0];
        col_q     <= RUN_W'(in_data_i.pos_x);
        col_end_q <= xe[RUN_W-1:0];
        x_q       <= '0;
        y_q       <= '0;
        bin_q     <= '0;
      end
      if (state_q == ST_PLACE) begin
        if (!row_done) begin
          row_q <= row_q + RUN_W'(1);
        end
        if (!col_done) begin
          col_q <= col_q + RUN_W'(1);
        end
      end
      if (state_q == ST_SCAN) begin
        if (x_last) begin
          x_q <= '0;
          y_q <= y_q + YW'(1);
        end else begin
          x_q <= x_q + XW'(1);
        end
      end
      if (out_load && !bin_last) begin
        bin_q <= bin_q + RUN_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
